/* hw/rtl/pmpl_pkg.sv */
// ----------------------------------------------------------------------------
// pmpl_pkg
// Shared types, register map and constants of the motor position loop.
// ----------------------------------------------------------------------------
package pmpl_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [2:0] REG_TARGET_POSITION = 3'd0;
   localparam logic [2:0] REG_KP_GAIN         = 3'd1;
   localparam logic [2:0] REG_KI_GAIN         = 3'd2;
   localparam logic [2:0] REG_INTEGRAL_LIMIT  = 3'd3;
   localparam logic [2:0] REG_DUTY_MAX        = 3'd4;

   localparam logic signed [23:0] TARGET_RESET = 24'sd16400;
   localparam logic [15:0]        KP_RESET     = 16'd384;
   localparam logic [23:0]        KI_RESET     = 24'd47416;
   localparam logic [29:0]        LIMIT_RESET  = 30'd50000000;
   localparam logic [7:0]         DUTY_RESET   = 8'd255;

   localparam logic CMD_EDGE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_ERROR,
      OP_MUL_STEP,
      OP_INTEG,
      OP_MUL_P,
      OP_MUL_I,
      OP_DRIVE
   } pmpl_op_type;

   typedef struct packed {
      logic signed [23:0] target_position;
      logic [15:0]        kp_gain;
      logic [23:0]        ki_gain;
      logic [29:0]        integral_limit;
      logic [7:0]         duty_max;
   } pmpl_cfg_type;

   typedef struct packed {
      logic        load_edge;
      logic        load_tick;
      pmpl_op_type op;
   } pmpl_ctl_type;

   typedef struct packed {
      logic out_full;
   } pmpl_stat_type;

endpackage

/* hw/rtl/pmpl_if.sv */
// ----------------------------------------------------------------------------
// pmpl_if
// Request and response channels of the motor position loop.
// ----------------------------------------------------------------------------
interface pmpl_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic        edge_forward;
   logic [19:0] elapsed_us;

   modport source (output valid, cmd, edge_forward, elapsed_us, input ready);
   modport sink   (input valid, cmd, edge_forward, elapsed_us, output ready);
endinterface

interface pmpl_rsp_if;
   logic               valid;
   logic               ready;
   logic [7:0]         pwm_duty;
   logic               drive_close;
   logic signed [31:0] drive_value;
   logic signed [23:0] position_now;

   modport source (output valid, pwm_duty, drive_close, drive_value, position_now,
                   input ready);
   modport sink   (input valid, pwm_duty, drive_close, drive_value, position_now,
                   output ready);
endinterface

/* hw/rtl/pmpl_csr.sv */
// ----------------------------------------------------------------------------
// pmpl_csr
// APB register file holding the loop setpoint, gains and limits.
// ----------------------------------------------------------------------------
module pmpl_csr import pmpl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output pmpl_cfg_type          cfg
);

   pmpl_cfg_type cfg_ff;
   logic         wr_en;
   logic [2:0]   reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[4:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target_position <= TARGET_RESET;
         cfg_ff.kp_gain         <= KP_RESET;
         cfg_ff.ki_gain         <= KI_RESET;
         cfg_ff.integral_limit  <= LIMIT_RESET;
         cfg_ff.duty_max        <= DUTY_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_TARGET_POSITION: cfg_ff.target_position <= $signed(csr_pwdata[23:0]);
            REG_KP_GAIN:         cfg_ff.kp_gain         <= csr_pwdata[15:0];
            REG_KI_GAIN:         cfg_ff.ki_gain         <= csr_pwdata[23:0];
            REG_INTEGRAL_LIMIT:  cfg_ff.integral_limit  <= csr_pwdata[29:0];
            REG_DUTY_MAX:        cfg_ff.duty_max        <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TARGET_POSITION: csr_prdata = {8'b0, cfg_ff.target_position};
         REG_KP_GAIN:         csr_prdata = {16'b0, cfg_ff.kp_gain};
         REG_KI_GAIN:         csr_prdata = {8'b0, cfg_ff.ki_gain};
         REG_INTEGRAL_LIMIT:  csr_prdata = {2'b0, cfg_ff.integral_limit};
         REG_DUTY_MAX:        csr_prdata = {24'b0, cfg_ff.duty_max};
         default:             csr_prdata = '0;
      endcase
   end

endmodule

/* hw/rtl/pmpl_ctrl.sv */
// ----------------------------------------------------------------------------
// pmpl_ctrl
// Sequencer stepping the datapath through one control tick.
// ----------------------------------------------------------------------------
module pmpl_ctrl import pmpl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_cmd,
   output logic          req_ready,
   input  pmpl_stat_type stat,
   output pmpl_ctl_type  ctl
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERROR,
      ST_MUL_STEP,
      ST_INTEG,
      ST_MUL_P,
      ST_MUL_I,
      ST_DRIVE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      ctl.load_edge = accept && (req_cmd == CMD_EDGE);
      ctl.load_tick = accept && (req_cmd == CMD_TICK);
      ctl.op        = OP_NONE;
      state_in      = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.load_tick) state_in = ST_ERROR;
         end
         ST_ERROR: begin
            ctl.op   = OP_ERROR;
            state_in = ST_MUL_STEP;
         end
         ST_MUL_STEP: begin
            ctl.op   = OP_MUL_STEP;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            ctl.op   = OP_INTEG;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            ctl.op   = OP_MUL_P;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            ctl.op   = OP_MUL_I;
            state_in = ST_DRIVE;
         end
         ST_DRIVE: begin
            if (!stat.out_full) begin
               ctl.op   = OP_DRIVE;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      ctl.load_tick |=> state_ff == ST_ERROR)
      else $error("tick accepted without starting the sequence");

   a_drive_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctl.op == OP_DRIVE |-> !stat.out_full)
      else $error("result written over a pending item");

   a_drive_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DRIVE && stat.out_full |=> state_ff == ST_DRIVE)
      else $error("drive step left while result pending");

endmodule

/* hw/rtl/pmpl_datapath.sv */
// ----------------------------------------------------------------------------
// pmpl_datapath
// Position counter, PI arithmetic on one shared multiplier, result register.
// ----------------------------------------------------------------------------
module pmpl_datapath import pmpl_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  pmpl_cfg_type       cfg,
   input  pmpl_ctl_type       ctl,
   output pmpl_stat_type      stat,
   input  logic               req_edge_forward,
   input  logic [19:0]        req_elapsed_us,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_pwm_duty,
   output logic               rsp_drive_close,
   output logic signed [31:0] rsp_drive_value,
   output logic signed [23:0] rsp_position_now
);

   logic signed [23:0] position_ff;
   logic signed [31:0] integral_ff,   integral_in;
   logic signed [24:0] last_error_ff;
   logic [19:0]        elapsed_ff;
   logic signed [24:0] error_ff,      error_in;
   logic signed [25:0] esum_ff,       esum_in;
   logic signed [63:0] prod_ff;
   logic signed [40:0] pterm_ff;

   logic               rsp_valid_ff;
   logic [7:0]         duty_ff,       duty_in;
   logic               close_ff,      close_in;
   logic signed [31:0] drive_ff,      drive_in;
   logic signed [23:0] pos_out_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic signed [47:0] sum_w, lim_w;
   logic signed [42:0] total;
   logic signed [34:0] drive_w;
   logic [32:0]        mag;

   assign error_in = {cfg.target_position[23], cfg.target_position}
                   - {position_ff[23], position_ff};
   assign esum_in  = {error_in[24], error_in} + {last_error_ff[24], last_error_ff};

   always_comb begin
      unique case (ctl.op)
         OP_MUL_STEP: begin
            mul_a = {{6{esum_ff[25]}}, esum_ff};
            mul_b = {12'b0, elapsed_ff};
         end
         OP_MUL_P: begin
            mul_a = {16'b0, cfg.kp_gain};
            mul_b = {{7{error_ff[24]}}, error_ff};
         end
         OP_MUL_I: begin
            mul_a = {8'b0, cfg.ki_gain};
            mul_b = integral_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // trapezoid step is prod/2 with floor; clamp at or beyond the limit
   always_comb begin
      sum_w = {{16{integral_ff[31]}}, integral_ff} + {prod_ff[47], prod_ff[47:1]};
      lim_w = {18'b0, cfg.integral_limit};
      if (sum_w >= lim_w) begin
         integral_in = lim_w[31:0];
      end else if (sum_w <= -lim_w) begin
         integral_in = 32'(-lim_w);
      end else begin
         integral_in = sum_w[31:0];
      end
   end

   // drive = floor((kp*e*2^28 + ki*I) / 2^36), saturated
   always_comb begin
      total   = {{2{pterm_ff[40]}}, pterm_ff} + {{7{prod_ff[63]}}, prod_ff[63:28]};
      drive_w = total[42:8];
      if (drive_w[34:31] != {4{drive_w[31]}}) begin
         drive_in = drive_w[34] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
         drive_in = drive_w[31:0];
      end
      mag      = drive_in[31] ? 33'(-{drive_in[31], drive_in}) : {1'b0, drive_in};
      duty_in  = (mag >= {25'b0, cfg.duty_max}) ? cfg.duty_max : mag[7:0];
      close_in = !drive_in[31] && (drive_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         integral_ff   <= '0;
         last_error_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (ctl.load_edge) begin
            position_ff <= req_edge_forward ? position_ff + 24'sd1 : position_ff - 24'sd1;
         end
         if (ctl.op == OP_INTEG) begin
            integral_ff   <= integral_in;
            last_error_ff <= error_ff;
         end
         if (ctl.op == OP_DRIVE) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_tick) elapsed_ff <= req_elapsed_us;
      if (ctl.op == OP_ERROR) begin
         error_ff <= error_in;
         esum_ff  <= esum_in;
      end
      if (ctl.op == OP_MUL_STEP || ctl.op == OP_MUL_P || ctl.op == OP_MUL_I) begin
         prod_ff <= mul_p;
      end
      if (ctl.op == OP_MUL_I) pterm_ff <= prod_ff[40:0];
      if (ctl.op == OP_DRIVE) begin
         duty_ff    <= duty_in;
         close_ff   <= close_in;
         drive_ff   <= drive_in;
         pos_out_ff <= position_ff;
      end
   end

   assign stat.out_full    = rsp_valid_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pwm_duty     = duty_ff;
   assign rsp_drive_close  = close_ff;
   assign rsp_drive_value  = drive_ff;
   assign rsp_position_now = pos_out_ff;

   a_rsp_from_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff) |-> $past(ctl.op == OP_DRIVE))
      else $error("result raised without a drive step");

   a_position_on_edge: assert property (@(posedge clock) disable iff (reset)
      !$stable(position_ff) |-> $past(ctl.load_edge))
      else $error("position moved without an edge item");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(drive_ff))
      else $error("pending result dropped or changed");

endmodule

/* hw/rtl/pi_motor_position_loop_top.sv */
// ----------------------------------------------------------------------------
// pi_motor_position_loop_top
// PI position loop for a DC motor with trapezoidal, clamped integral.
//
//   port   dir  kind             item
//   req    in   valid/ready      cmd, edge_forward, elapsed_us
//   rsp    out  valid/ready      pwm_duty, drive_close, drive_value, position_now
//   csr_*  in   APB, 5-bit addr  target, kp, ki, integral limit, duty max
//
// Edge item: steps the position count, no result.
// Tick item: rsp valid after its drive step; no new item is taken until the sequence ends;
// the six steps run on one shared 32x32 multiplier (step, kp and ki products).
// A pending result holds the next tick at its drive step; req stalls meanwhile.
// reset is synchronous, active high; no clearing pass.
// ----------------------------------------------------------------------------
module pi_motor_position_loop_top import pmpl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pmpl_req_if.sink              req,
   pmpl_rsp_if.source            rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   pmpl_cfg_type  cfg;
   pmpl_ctl_type  ctl;
   pmpl_stat_type stat;

   pmpl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pmpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_cmd   (req.cmd),
      .req_ready (req.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   pmpl_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .ctl              (ctl),
      .stat             (stat),
      .req_edge_forward (req.edge_forward),
      .req_elapsed_us   (req.elapsed_us),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_pwm_duty     (rsp.pwm_duty),
      .rsp_drive_close  (rsp.drive_close),
      .rsp_drive_value  (rsp.drive_value),
      .rsp_position_now (rsp.position_now)
   );

endmodule
